[sv/tpg_pkg.sv]
// tpg_pkg: shared types and constants for the touch-plane gesture recogniser
// used by tpg_cfg, tpg_ctrl, tpg_dp and the top level

package tpg_pkg;

  // field widths
  localparam int COORD_W    = 16;
  localparam int IN_TIME_W  = 32;
  localparam int VIEW_W     = 13;
  localparam int HOVER_W    = 15;
  localparam int THR_W      = 12;
  localparam int GAP_W      = 16;
  localparam int PIX_W      = 14;
  localparam int WHEEL_W    = 16;
  localparam int KIND_W     = 3;
  localparam int IN_DATA_W  = 5 * COORD_W + IN_TIME_W;
  localparam int OUT_DATA_W = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int NUM_EV     = 5;

  // surface unit and pixel mapping
  localparam int UNIT_SCALE = 100;
  localparam int SCALE_W    = 7;
  localparam int PIX_BASE   = 4096;
  localparam int PIX_BIAS   = PIX_BASE * UNIT_SCALE;
  localparam int UX_MAX     = (8192 + PIX_BASE) * UNIT_SCALE - 1;
  localparam int UX_W       = 21;
  localparam int RECIP_W    = 22;
  localparam int RECIP_SH   = 28;
  localparam logic [RECIP_W-1:0] RECIP = 22'd2684355;

  // wheel division
  localparam int WHEEL_FRAC_BITS = 8;
  localparam int QBITS           = 15;
  localparam int DVS_W           = THR_W + SCALE_W;
  localparam logic [WHEEL_W-1:0] WHEEL_MAX = 16'h7fff;
  localparam logic [WHEEL_W-1:0] WHEEL_MIN = 16'h8000;

  typedef enum logic [KIND_W-1:0] {
    EV_MOVE    = 3'd0,
    EV_PRESS   = 3'd1,
    EV_RELEASE = 3'd2,
    EV_WHEEL   = 3'd3,
    EV_BACK    = 3'd4
  } ev_kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VIEW_WIDTH   = 3'd0,
    CFG_VIEW_HEIGHT  = 3'd1,
    CFG_HOVER_DIST   = 3'd2,
    CFG_SCROLL_THR   = 3'd3,
    CFG_PIX_PER_TICK = 3'd4,
    CFG_SWIPE_THR    = 3'd5,
    CFG_MIN_GAP      = 3'd6,
    CFG_MAX_LINK     = 3'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    MS_NONE = 3'd0,
    MS_NX   = 3'd1,
    MS_NY   = 3'd2,
    MS_DX   = 3'd3,
    MS_DY   = 3'd4,
    MS_QX   = 3'd5,
    MS_QY   = 3'd6
  } mul_sel_e;

  typedef struct packed {
    logic [VIEW_W-1:0]  view_width;
    logic [VIEW_W-1:0]  view_height;
    logic [HOVER_W-1:0] hover_distance;
    logic [THR_W-1:0]   scroll_threshold;
    logic [THR_W-1:0]   pixels_per_wheel_tick;
    logic [THR_W-1:0]   swipe_threshold;
    logic [GAP_W-1:0]   min_swipe_gap_ms;
    logic [GAP_W-1:0]   max_link_gap_ms;
  } cfg_t;

  typedef struct packed {
    mul_sel_e mul;
    logic     prep;
    logic     div_step;
    logic     commit;
  } cmd_t;

  typedef struct packed {
    logic across;
    logic hover;
    logic wheel_hit;
    logic back;
  } status_t;

  localparam cfg_t CFG_RST = '{
    view_width:            13'd1024,
    view_height:           13'd768,
    hover_distance:        15'd7680,
    scroll_threshold:      12'd3,
    pixels_per_wheel_tick: 12'd100,
    swipe_threshold:       12'd40,
    min_swipe_gap_ms:      16'd500,
    max_link_gap_ms:       16'd1500
  };

endpackage

[sv/tpg_cfg.sv]
// tpg_cfg: configuration register bank, written through a plain write port
// depends on tpg_pkg

module tpg_cfg
  import tpg_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  we_i,
  input  logic [CFG_IDX_W-1:0]  idx_i,
  input  logic [CFG_DATA_W-1:0] wdata_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RST;
    end else if (we_i) begin
      case (cfg_idx_e'(idx_i))
        CFG_VIEW_WIDTH:   cfg_q.view_width            <= wdata_i[VIEW_W-1:0];
        CFG_VIEW_HEIGHT:  cfg_q.view_height           <= wdata_i[VIEW_W-1:0];
        CFG_HOVER_DIST:   cfg_q.hover_distance        <= wdata_i[HOVER_W-1:0];
        CFG_SCROLL_THR:   cfg_q.scroll_threshold      <= wdata_i[THR_W-1:0];
        CFG_PIX_PER_TICK: cfg_q.pixels_per_wheel_tick <= wdata_i[THR_W-1:0];
        CFG_SWIPE_THR:    cfg_q.swipe_threshold       <= wdata_i[THR_W-1:0];
        CFG_MIN_GAP:      cfg_q.min_swipe_gap_ms      <= wdata_i[GAP_W-1:0];
        CFG_MAX_LINK:     cfg_q.max_link_gap_ms       <= wdata_i[GAP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

[sv/tpg_ctrl.sv]
// tpg_ctrl: sequencing state machine, event selection and output handshake
// depends on tpg_pkg; drives tpg_dp through cmd_t, reads status_t

module tpg_ctrl
  import tpg_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output ev_kind_e out_kind_o,
  output logic     out_last_o,
  output cmd_t     cmd_o,
  input  status_t  status_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_NX, S_NY, S_DX, S_DY, S_PREP, S_DIV, S_DECIDE, S_EMIT
  } state_e;

  localparam int CNT_W = $clog2(QBITS);

  state_e              state_q;
  logic                ready_q;
  logic                valid_q;
  ev_kind_e            kind_q;
  logic                last_q;
  cmd_t                cmd_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [NUM_EV-1:0]   mask_q;
  logic                across_q;

  logic [NUM_EV-1:0]   dec_mask;
  logic [NUM_EV-1:0]   pick_src;
  logic [NUM_EV-1:0]   pick_rest;
  ev_kind_e            pick_kind;

  function automatic ev_kind_e first_ev(logic [NUM_EV-1:0] m);
    if (m[EV_PRESS]) begin
      return EV_PRESS;
    end else if (m[EV_RELEASE]) begin
      return EV_RELEASE;
    end else if (m[EV_WHEEL]) begin
      return EV_WHEEL;
    end else if (m[EV_BACK]) begin
      return EV_BACK;
    end else begin
      return EV_MOVE;
    end
  endfunction

  // events of this frame, one bit per kind
  always_comb begin
    dec_mask = '0;
    if (status_i.across) begin
      dec_mask[EV_PRESS] = !across_q;
      dec_mask[EV_WHEEL] = status_i.wheel_hit;
      dec_mask[EV_BACK]  = status_i.back;
    end else begin
      dec_mask[EV_RELEASE] = across_q;
      dec_mask[EV_MOVE]    = status_i.hover;
    end
  end

  always_comb begin
    pick_src  = (state_q == S_DECIDE) ? dec_mask : mask_q;
    pick_kind = first_ev(pick_src);
    pick_rest = pick_src & ~(NUM_EV'(1) << pick_kind);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ready_q  <= 1'b1;
      valid_q  <= 1'b0;
      kind_q   <= EV_MOVE;
      last_q   <= 1'b0;
      cmd_q    <= '0;
      cnt_q    <= '0;
      mask_q   <= '0;
      across_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i && ready_q) begin
            ready_q   <= 1'b0;
            cmd_q.mul <= MS_NX;
            state_q   <= S_NX;
          end
        end
        S_NX: begin
          cmd_q.mul <= MS_NY;
          state_q   <= S_NY;
        end
        S_NY: begin
          cmd_q.mul <= MS_DX;
          state_q   <= S_DX;
        end
        S_DX: begin
          cmd_q.mul <= MS_DY;
          state_q   <= S_DY;
        end
        S_DY: begin
          cmd_q.mul  <= MS_NONE;
          cmd_q.prep <= 1'b1;
          state_q    <= S_PREP;
        end
        S_PREP: begin
          cmd_q.prep     <= 1'b0;
          cmd_q.div_step <= 1'b1;
          cmd_q.mul      <= MS_QX;
          cnt_q          <= '0;
          state_q        <= S_DIV;
        end
        S_DIV: begin
          cnt_q     <= cnt_q + 1'b1;
          cmd_q.mul <= (cnt_q == '0) ? MS_QY : MS_NONE;
          if (cnt_q == CNT_W'(QBITS - 1)) begin
            cmd_q.div_step <= 1'b0;
            cmd_q.commit   <= 1'b1;
            state_q        <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          cmd_q.commit <= 1'b0;
          across_q     <= status_i.across;
          if (dec_mask == '0) begin
            ready_q <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            valid_q <= 1'b1;
            kind_q  <= pick_kind;
            last_q  <= (pick_rest == '0);
            mask_q  <= pick_rest;
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_ready_i) begin
            if (mask_q == '0) begin
              valid_q <= 1'b0;
              ready_q <= 1'b1;
              state_q <= S_IDLE;
            end else begin
              kind_q <= pick_kind;
              last_q <= (pick_rest == '0);
              mask_q <= pick_rest;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = ready_q;
  assign out_valid_o = valid_q;
  assign out_kind_o  = kind_q;
  assign out_last_o  = last_q;
  assign cmd_o       = cmd_q;

endmodule

[sv/tpg_dp.sv]
// tpg_dp: frame registers, shared multiplier, wheel divider and gesture state
// depends on tpg_pkg; sequenced by tpg_ctrl

module tpg_dp
  import tpg_pkg::*;
#(
  parameter int COORD_FRAC_BITS = 8,
  parameter int TIME_BITS       = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        load_i,
  input  logic signed [COORD_W-1:0]   finger_x_i,
  input  logic signed [COORD_W-1:0]   finger_y_i,
  input  logic signed [COORD_W-1:0]   finger_z_i,
  input  logic signed [COORD_W-1:0]   palm_x_i,
  input  logic signed [COORD_W-1:0]   palm_y_i,
  input  logic        [IN_TIME_W-1:0] time_ms_i,
  input  cfg_t                        cfg_i,
  input  cmd_t                        cmd_i,
  output status_t                     status_o,
  output logic signed [PIX_W-1:0]     pixel_x_o,
  output logic signed [PIX_W-1:0]     pixel_y_o,
  output logic signed [WHEEL_W-1:0]   wheel_ticks_o
);

  localparam int OFF   = (UNIT_SCALE / 2) << COORD_FRAC_BITS;
  localparam int CW    = $clog2(OFF + 2 ** (COORD_W - 1)) + 1;
  localparam int MA    = (CW > UX_W + 1) ? CW : UX_W + 1;
  localparam int MB    = RECIP_W + 1;
  localparam int PW    = MA + MB;
  localparam int NW    = CW + VIEW_W + 1;
  localparam int DW    = COORD_W + VIEW_W + 2;
  localparam int AW    = DW - 1;
  localparam int TW    = THR_W + SCALE_W + COORD_FRAC_BITS;
  localparam int CMPW  = (TW > AW) ? TW : AW;
  localparam int DVW   = AW + WHEEL_FRAC_BITS - COORD_FRAC_BITS;
  localparam int SW    = (DVW > DVS_W + QBITS) ? DVW : DVS_W + QBITS;
  localparam int DSR_W = DVS_W + QBITS - 1;
  localparam int RW    = (DVW > DSR_W) ? DVW : DSR_W;

  localparam logic signed [NW-1:0] V_LO = NW'(-PIX_BIAS);
  localparam logic signed [NW-1:0] V_HI = NW'(UX_MAX - PIX_BIAS);

  // frame
  logic signed [COORD_W-1:0] fx_q, fy_q, fz_q, pxv_q, pyv_q;
  logic [TIME_BITS-1:0]      now_q;
  // gesture state
  logic signed [COORD_W-1:0] prev_x_q, prev_y_q;
  logic [TIME_BITS-1:0]      last_l_q, last_r_q;
  // work registers
  logic signed [NW-1:0]      numx_q, numy_q;
  logic signed [DW-1:0]      dx_q, dy_q;
  logic [UX_W-1:0]           ux_q, uy_q;
  logic [PIX_W-1:0]          pix_x_q, pix_y_q;
  logic                      wheel_hit_q, swipe_q, dx_neg_q, dy_neg_q, sat_q;
  logic [DVW-1:0]            rem_q;
  logic [DSR_W-1:0]          dsr_q;
  logic [QBITS-1:0]          quo_q;

  logic signed [MA-1:0]      mul_a;
  logic signed [MB-1:0]      mul_b;
  logic signed [PW-1:0]      prod;

  logic [AW-1:0]             ady, adx;
  logic [CMPW-1:0]           scroll_lim, swipe_lim;
  logic [AW+WHEEL_FRAC_BITS-1:0] ady_w;
  logic [DVW-1:0]            divd;
  logic [THR_W-1:0]          ppt_eff;
  logic [DVS_W-1:0]          dvs;
  logic                      sat;
  logic                      div_ge;
  logic [DVW-1:0]            div_sub;
  logic [TIME_BITS-1:0]      el_l, el_r;
  logic                      gap_ok_l, gap_ok_r, link_ok, across;
  logic [WHEEL_W-1:0]        wheel_mag;

  function automatic logic [UX_W-1:0] to_ux(logic signed [NW-1:0] num);
    logic signed [NW-1:0] v;
    v = num >>> COORD_FRAC_BITS;
    if (v < V_LO) begin
      v = V_LO;
    end else if (v > V_HI) begin
      v = V_HI;
    end
    return UX_W'(v - V_LO);
  endfunction

  // shared multiplier
  always_comb begin
    case (cmd_i.mul)
      MS_NX: begin
        mul_a = MA'(fx_q) + MA'(OFF);
        mul_b = MB'($signed({1'b0, cfg_i.view_width}));
      end
      MS_NY: begin
        mul_a = MA'(fy_q) + MA'(OFF);
        mul_b = MB'($signed({1'b0, cfg_i.view_height}));
      end
      MS_DX: begin
        mul_a = MA'(pxv_q) - MA'(prev_x_q);
        mul_b = MB'($signed({1'b0, cfg_i.view_width}));
      end
      MS_DY: begin
        mul_a = MA'(pyv_q) - MA'(prev_y_q);
        mul_b = MB'($signed({1'b0, cfg_i.view_height}));
      end
      MS_QX: begin
        mul_a = MA'($signed({1'b0, ux_q}));
        mul_b = MB'($signed({1'b0, RECIP}));
      end
      MS_QY: begin
        mul_a = MA'($signed({1'b0, uy_q}));
        mul_b = MB'($signed({1'b0, RECIP}));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod = mul_a * mul_b;
  end

  // thresholds and divider set-up
  always_comb begin
    ady        = dy_q[DW-1] ? AW'(-dy_q) : AW'(dy_q);
    adx        = dx_q[DW-1] ? AW'(-dx_q) : AW'(dx_q);
    scroll_lim = (CMPW'(cfg_i.scroll_threshold) * CMPW'(UNIT_SCALE)) << COORD_FRAC_BITS;
    swipe_lim  = (CMPW'(cfg_i.swipe_threshold) * CMPW'(UNIT_SCALE)) << COORD_FRAC_BITS;
    ady_w      = {ady, {WHEEL_FRAC_BITS{1'b0}}};
    divd       = DVW'(ady_w >> COORD_FRAC_BITS);
    ppt_eff    = (cfg_i.pixels_per_wheel_tick == '0) ? THR_W'(1) : cfg_i.pixels_per_wheel_tick;
    dvs        = DVS_W'(ppt_eff) * DVS_W'(UNIT_SCALE);
    sat        = SW'(divd) >= (SW'(dvs) << QBITS);
    div_ge     = RW'(rem_q) >= RW'(dsr_q);
    div_sub    = DVW'(RW'(rem_q) - RW'(dsr_q));
  end

  // swipe timing
  always_comb begin
    el_l     = now_q - last_l_q;
    el_r     = now_q - last_r_q;
    gap_ok_l = el_l >= TIME_BITS'(cfg_i.min_swipe_gap_ms);
    gap_ok_r = el_r >= TIME_BITS'(cfg_i.min_swipe_gap_ms);
    link_ok  = el_l <= TIME_BITS'(cfg_i.max_link_gap_ms);
    across   = fz_q[COORD_W-1] || (fz_q == '0);
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      fx_q  <= finger_x_i;
      fy_q  <= finger_y_i;
      fz_q  <= finger_z_i;
      pxv_q <= palm_x_i;
      pyv_q <= palm_y_i;
      now_q <= TIME_BITS'(time_ms_i);
    end
    case (cmd_i.mul)
      MS_NX: numx_q <= prod[NW-1:0];
      MS_NY: numy_q <= prod[NW-1:0];
      MS_DX: dx_q   <= prod[DW-1:0];
      MS_DY: dy_q   <= prod[DW-1:0];
      MS_QX: pix_x_q <= PIX_W'({1'b0, prod[RECIP_SH +: PIX_W]} - (PIX_W + 1)'(PIX_BASE));
      MS_QY: pix_y_q <= PIX_W'({1'b0, prod[RECIP_SH +: PIX_W]} - (PIX_W + 1)'(PIX_BASE));
      default: begin
      end
    endcase
    if (cmd_i.prep) begin
      ux_q        <= to_ux(numx_q);
      uy_q        <= to_ux(numy_q);
      wheel_hit_q <= CMPW'(ady) >= scroll_lim;
      swipe_q     <= CMPW'(adx) >= swipe_lim;
      dx_neg_q    <= dx_q[DW-1];
      dy_neg_q    <= dy_q[DW-1];
      sat_q       <= sat;
      rem_q       <= divd;
      dsr_q       <= DSR_W'(dvs) << (QBITS - 1);
      quo_q       <= '0;
    end else if (cmd_i.div_step) begin
      if (div_ge) begin
        rem_q <= div_sub;
      end
      quo_q <= {quo_q[QBITS-2:0], div_ge};
      dsr_q <= dsr_q >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q <= '0;
      prev_y_q <= '0;
      last_l_q <= '0;
      last_r_q <= '0;
    end else if (cmd_i.commit) begin
      prev_x_q <= pxv_q;
      prev_y_q <= pyv_q;
      if (across && swipe_q) begin
        if (dx_neg_q && gap_ok_l) begin
          last_l_q <= now_q;
        end
        if (!dx_neg_q && gap_ok_r) begin
          last_r_q <= now_q;
        end
      end
    end
  end

  assign wheel_mag = {1'b0, quo_q};

  always_comb begin
    if (sat_q) begin
      wheel_ticks_o = dy_neg_q ? WHEEL_MIN : WHEEL_MAX;
    end else begin
      wheel_ticks_o = dy_neg_q ? -wheel_mag : wheel_mag;
    end
  end

  assign status_o.across    = across;
  assign status_o.hover     = $signed(fz_q) <= $signed({1'b0, cfg_i.hover_distance});
  assign status_o.wheel_hit = wheel_hit_q;
  assign status_o.back      = across && swipe_q && !dx_neg_q && gap_ok_r && link_ok;
  assign pixel_x_o          = pix_x_q;
  assign pixel_y_o          = pix_y_q;

endmodule

[sv/touch_plane_gesture_recognizer.sv]
// touch_plane_gesture_recognizer: top level of the touch-plane gesture recogniser
// depends on tpg_pkg, tpg_cfg, tpg_ctrl, tpg_dp
//
// usage
// - slave stream: one tracked-hand frame per transaction on s_axis_tdata
// - master stream: zero to three pointer events per frame, kind on m_axis_tuser,
//   m_axis_tlast on the final event of the frame
// - config port: cfg_we_i writes cfg_wdata_i to register cfg_idx_i; the user
//   must do so only while idle, which the block itself does not enforce
// - a frame steps through states NX, NY, DX, DY, PREP, DIV and DECIDE before its
//   first event, or before s_axis_tready returns when it causes none; the wheel
//   divider makes one quotient bit per cycle in DIV
// - each further event is presented as soon as the previous one is taken
// - a new frame is accepted in the cycle after the last event is taken
// reset
// - clears the finger-across flag, previous palm position, swipe times
//   and the config registers to their defaults
// stall
// - a held event stays on the master stream unchanged and no new frame is
//   taken until every event of the current one has been delivered

module touch_plane_gesture_recognizer
  import tpg_pkg::*;
#(
  parameter int COORD_FRAC_BITS = 8,
  parameter int TIME_BITS       = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // finger_x, finger_y, finger_z, palm_x, palm_y, time_ms
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // pixel_x, pixel_y, wheel_ticks, zero padding
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // event_kind
  output logic [KIND_W-1:0]     m_axis_tuser,
  output logic                  m_axis_tlast,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  cfg_t                      cfg;
  cmd_t                      cmd;
  status_t                   status;
  ev_kind_e                  out_kind;
  logic                      load;
  logic signed [PIX_W-1:0]   pix_x, pix_y;
  logic signed [WHEEL_W-1:0] wheel;
  logic                      has_pix;

  tpg_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  tpg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (out_kind),
    .out_last_o  (m_axis_tlast),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  assign load = s_axis_tvalid && s_axis_tready;

  tpg_dp #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS),
    .TIME_BITS       (TIME_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .finger_x_i    (s_axis_tdata[15:0]),
    .finger_y_i    (s_axis_tdata[31:16]),
    .finger_z_i    (s_axis_tdata[47:32]),
    .palm_x_i      (s_axis_tdata[63:48]),
    .palm_y_i      (s_axis_tdata[79:64]),
    .time_ms_i     (s_axis_tdata[111:80]),
    .cfg_i         (cfg),
    .cmd_i         (cmd),
    .status_o      (status),
    .pixel_x_o     (pix_x),
    .pixel_y_o     (pix_y),
    .wheel_ticks_o (wheel)
  );

  assign has_pix = (out_kind == EV_MOVE) || (out_kind == EV_PRESS) ||
                   (out_kind == EV_RELEASE);

  assign m_axis_tuser = out_kind;
  assign m_axis_tdata = {
    {(OUT_DATA_W - 2 * PIX_W - WHEEL_W){1'b0}},
    (out_kind == EV_WHEEL) ? wheel : {WHEEL_W{1'b0}},
    has_pix ? pix_y : {PIX_W{1'b0}},
    has_pix ? pix_x : {PIX_W{1'b0}}
  };

endmodule
